FILE: hw/rtl/rcs_pkg.sv
package rcs_pkg;

	localparam int CHAR_W      = 7;
	localparam int LEVEL_W     = 8;
	localparam int CRC_W       = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_PRESET = 16'hFFFF;

	localparam logic [LEVEL_W-1:0] ONE_LEVEL_RESET  = 8'd100;
	localparam logic [LEVEL_W-1:0] ZERO_LEVEL_RESET = 8'd110;

	localparam logic [CFG_INDEX_W-1:0] CFG_ONE_LEVEL  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_LEVEL = 2'd1;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              in_checksum;
		logic              start_sentence;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] line_level;
		logic               bit_value;
		logic               end_of_frame;
		logic [CRC_W-1:0]   checksum;
	} out_item_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [CHAR_W-1:0] ch);
		logic [CRC_W-1:0] c;
		c = crc ^ {1'b0, ch, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/rcs_crc_stage.sv
module rcs_crc_stage import rcs_pkg::*; #(
	parameter int DATA_BITS     = 7,
	parameter int FRAME_SYMBOLS = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	input  logic                     take,
	output logic                     s1_valid,
	output logic [FRAME_SYMBOLS-1:0] frame_s1,
	output logic [CRC_W-1:0]         crc_s1
);

	logic                     s1_valid_q;
	logic [CRC_W-1:0]         crc_q;
	logic [CRC_W-1:0]         crc_base;
	logic [CRC_W-1:0]         crc_nxt;
	logic [FRAME_SYMBOLS-1:0] frame_nxt;
	logic [7:0]               ch_ext;
	logic                     accept;

	assign in_stall = s1_valid_q && !take;
	assign accept   = in_valid && !in_stall;
	assign s1_valid = s1_valid_q;
	assign ch_ext   = {1'b0, in_data.character};

	always_comb begin
		crc_base = in_data.start_sentence ? CRC_PRESET : crc_q;
		crc_nxt  = in_data.in_checksum ? crc_feed(crc_base, in_data.character) : crc_base;
	end

	always_comb begin
		frame_nxt    = '1;
		frame_nxt[0] = 1'b0;
		for (int i = 0; i < DATA_BITS; i++) begin
			if (i + 1 < FRAME_SYMBOLS) begin
				frame_nxt[i+1] = ch_ext[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			crc_q      <= CRC_PRESET;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				crc_q      <= crc_nxt;
			end else if (take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame_nxt;
			crc_s1   <= crc_nxt;
		end
	end

endmodule

FILE: hw/rtl/rcs_serializer.sv
module rcs_serializer import rcs_pkg::*; #(
	parameter int FRAME_SYMBOLS = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s1_valid,
	input  logic [FRAME_SYMBOLS-1:0] frame_s1,
	input  logic [CRC_W-1:0]         crc_s1,
	output logic                     take,
	input  logic [LEVEL_W-1:0]       one_level,
	input  logic [LEVEL_W-1:0]       zero_level,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data
);

	localparam int REM_W = $clog2(FRAME_SYMBOLS);
	localparam logic [REM_W-1:0] REM_LOAD = REM_W'(FRAME_SYMBOLS - 1);

	logic [FRAME_SYMBOLS-2:0] sh_s2;
	logic [REM_W-1:0]         rem_q;
	logic [CRC_W-1:0]         crc_s2;
	logic                     out_valid_q;
	out_item_t                out_q;
	logic                     adv;
	logic                     busy;

	assign adv       = !out_valid_q || !out_stall;
	assign busy      = (rem_q != '0);
	assign take      = adv && !busy && s1_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (busy) begin
				rem_q       <= rem_q - 1'b1;
				out_valid_q <= 1'b1;
			end else if (s1_valid) begin
				rem_q       <= REM_LOAD;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy) begin
				sh_s2              <= sh_s2 >> 1;
				out_q.bit_value    <= sh_s2[0];
				out_q.line_level   <= sh_s2[0] ? one_level : zero_level;
				out_q.end_of_frame <= (rem_q == REM_W'(1));
				out_q.checksum     <= crc_s2;
			end else if (s1_valid) begin
				sh_s2              <= frame_s1[FRAME_SYMBOLS-1:1];
				crc_s2             <= crc_s1;
				out_q.bit_value    <= frame_s1[0];
				out_q.line_level   <= frame_s1[0] ? one_level : zero_level;
				out_q.end_of_frame <= 1'b0;
				out_q.checksum     <= crc_s1;
			end
		end
	end

endmodule

FILE: hw/rtl/rtty_char_serializer_crc16.sv
// Channel   Signals                       Moves
// in        in_valid / in_stall / in_data   one character per transfer
// out       out_valid / out_stall / out_data one line symbol per transfer
// cfg       cfg_we / cfg_index / cfg_wdata  one level register per write
//
// One character yields FRAME_SYMBOLS symbols from the symbol shift register, one per
// cycle unless out stalls; the next one waits in the input register and follows
// with no gap. The first symbol is registered on the output once the shift register
// takes the character from the input register. The CRC is updated in the input
// transfer cycle. Reset empties both registers and presets the CRC to 0xFFFF. Stalls
// on out freeze the shift register; in stalls when a full input register is not taken.
module rtty_char_serializer_crc16 import rcs_pkg::*; #(
	parameter int DATA_BITS     = 7,
	parameter int FRAME_SYMBOLS = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]     cfg_wdata
);

	logic [LEVEL_W-1:0]       one_level_q;
	logic [LEVEL_W-1:0]       zero_level_q;
	logic                     s1_valid;
	logic [FRAME_SYMBOLS-1:0] frame_s1;
	logic [CRC_W-1:0]         crc_s1;
	logic                     take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_level_q  <= ONE_LEVEL_RESET;
			zero_level_q <= ZERO_LEVEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ONE_LEVEL:  one_level_q  <= cfg_wdata;
				CFG_ZERO_LEVEL: zero_level_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rcs_crc_stage #(
		.DATA_BITS(DATA_BITS),
		.FRAME_SYMBOLS(FRAME_SYMBOLS)
	) u_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.take(take),
		.s1_valid(s1_valid),
		.frame_s1(frame_s1),
		.crc_s1(crc_s1)
	);

	rcs_serializer #(
		.FRAME_SYMBOLS(FRAME_SYMBOLS)
	) u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.s1_valid(s1_valid),
		.frame_s1(frame_s1),
		.crc_s1(crc_s1),
		.take(take),
		.one_level(one_level_q),
		.zero_level(zero_level_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

FILE: hw/rtl/rcs_checker.sv
module rcs_checker import rcs_pkg::*; #(
	parameter int DATA_BITS     = 7,
	parameter int FRAME_SYMBOLS = 11
) (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	localparam bit STOP_LAST = (FRAME_SYMBOLS >= DATA_BITS + 2);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

	a_crc_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.end_of_frame |=>
			out_valid && out_data.checksum == $past(out_data.checksum))
		else $error("frame broken or checksum changed within a frame");

	a_start_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.end_of_frame |=>
			!out_valid || !out_data.bit_value)
		else $error("frame does not open with a start bit");

	a_stop_bit: assert property (@(posedge clk) disable iff (!arst_n)
		STOP_LAST && out_valid && out_data.end_of_frame |-> out_data.bit_value)
		else $error("last symbol is not a stop bit");

endmodule

bind rtty_char_serializer_crc16 rcs_checker #(
	.DATA_BITS(DATA_BITS),
	.FRAME_SYMBOLS(FRAME_SYMBOLS)
) u_rcs_checker (.*);

FILE: verif/tb_rtty_char_serializer_crc16.sv
`timescale 1ns / 100ps

module tb_rtty_char_serializer_crc16;
	import rcs_pkg::*;

	localparam int DATA_BITS     = 7;
	localparam int FRAME_SYMBOLS = 11;
	localparam int N_DIRECTED    = 15;
	localparam int N_PHASES      = 4;
	localparam int PHASE_CHARS   = 46;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		in_item_t         item;
		logic             typed;
		logic [CRC_W-1:0] crc;
	} directed_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0]     cfg_wdata = '0;

	logic [CRC_W-1:0]   model_crc = CRC_PRESET;
	logic [LEVEL_W-1:0] lvl_one = ONE_LEVEL_RESET;
	logic [LEVEL_W-1:0] lvl_zero = ZERO_LEVEL_RESET;
	out_item_t          pending_symbols [$];
	int                 errors = 0;
	bit                 quiet = 1'b0;
	int                 row;
	int                 ph;
	logic [LEVEL_W-1:0] new_one;
	logic [LEVEL_W-1:0] new_zero;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{7'h00, 1'b0, 1'b0}, 1'b1, 16'hFFFF},
		'{'{7'h7F, 1'b0, 1'b0}, 1'b1, 16'hFFFF},
		'{'{7'h55, 1'b0, 1'b1}, 1'b1, 16'hFFFF},
		'{'{7'h2A, 1'b1, 1'b1}, 1'b0, 16'h0000},
		'{'{7'h41, 1'b1, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h00, 1'b1, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h7F, 1'b1, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h01, 1'b0, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h40, 1'b1, 1'b1}, 1'b0, 16'h0000},
		'{'{7'h24, 1'b1, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h0A, 1'b0, 1'b1}, 1'b1, 16'hFFFF},
		'{'{7'h7F, 1'b1, 1'b1}, 1'b0, 16'h0000},
		'{'{7'h00, 1'b1, 1'b1}, 1'b0, 16'h0000},
		'{'{7'h2C, 1'b1, 1'b0}, 1'b0, 16'h0000},
		'{'{7'h7E, 1'b0, 1'b0}, 1'b0, 16'h0000}
	};

	rtty_char_serializer_crc16 #(
		.DATA_BITS    (DATA_BITS),
		.FRAME_SYMBOLS(FRAME_SYMBOLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [CRC_W-1:0] crc_ccitt_char(input logic [CRC_W-1:0] crc,
			input logic [CHAR_W-1:0] ch);
		logic [CRC_W-1:0] r;
		logic             fb;
		r = crc ^ (CRC_W'(ch) << 8);
		for (int k = 0; k < 8; k++) begin
			fb = r[CRC_W-1];
			r = r << 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic void frame_symbols(input in_item_t it, input logic typed,
			input logic [CRC_W-1:0] typed_crc);
		out_item_t sym;
		logic      b;
		if (it.start_sentence) begin
			model_crc = CRC_PRESET;
		end
		if (it.in_checksum) begin
			model_crc = crc_ccitt_char(model_crc, it.character);
		end
		for (int s = 0; s < FRAME_SYMBOLS; s++) begin
			if (s == 0) begin
				b = 1'b0;
			end else if (s <= DATA_BITS) begin
				b = (s - 1 < CHAR_W) ? it.character[s-1] : 1'b0;
			end else begin
				b = 1'b1;
			end
			sym.line_level   = b ? lvl_one : lvl_zero;
			sym.bit_value    = b;
			sym.end_of_frame = (s == FRAME_SYMBOLS - 1);
			sym.checksum     = typed ? typed_crc : model_crc;
			pending_symbols.push_back(sym);
		end
	endfunction

	function automatic in_item_t random_char();
		in_item_t it;
		it.character      = CHAR_W'($urandom_range(0, 127));
		it.in_checksum    = ($urandom_range(0, 3) != 0);
		it.start_sentence = ($urandom_range(0, 5) == 0);
		return it;
	endfunction

	task automatic send_char(input in_item_t it, input logic typed,
			input logic [CRC_W-1:0] typed_crc);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		frame_symbols(it, typed, typed_crc);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_ONE_LEVEL:  lvl_one = val;
			CFG_ZERO_LEVEL: lvl_zero = val;
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		wait (arst_n);
		forever begin
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!quiet) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_symbols.size() == 0) begin
				$display("%0t: unexpected symbol transfer, actual %h", $time, out_data);
				errors++;
			end else begin
				if (out_data.line_level !== pending_symbols[0].line_level) begin
					$display("%0t: line_level expected %h actual %h", $time,
						pending_symbols[0].line_level, out_data.line_level);
					errors++;
				end
				if (out_data.bit_value !== pending_symbols[0].bit_value) begin
					$display("%0t: bit_value expected %b actual %b", $time,
						pending_symbols[0].bit_value, out_data.bit_value);
					errors++;
				end
				if (out_data.end_of_frame !== pending_symbols[0].end_of_frame) begin
					$display("%0t: end_of_frame expected %b actual %b", $time,
						pending_symbols[0].end_of_frame, out_data.end_of_frame);
					errors++;
				end
				if (out_data.checksum !== pending_symbols[0].checksum) begin
					$display("%0t: checksum expected %h actual %h", $time,
						pending_symbols[0].checksum, out_data.checksum);
					errors++;
				end
				void'(pending_symbols.pop_front());
			end
		end
	end

	initial begin
		#1000000;
		$display("FAIL rtty_char_serializer_crc16");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			send_char(directed_rows[row].item, directed_rows[row].typed,
				directed_rows[row].crc);
		end
		in_valid <= 1'b0;

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					new_one  = 8'h00;
					new_zero = 8'hFF;
				end
				1: begin
					new_one  = 8'hFF;
					new_zero = 8'h00;
				end
				default: begin
					new_one  = LEVEL_W'($urandom);
					new_zero = LEVEL_W'($urandom);
				end
			endcase
			cfg_write(CFG_ONE_LEVEL, new_one);
			cfg_write(CFG_ZERO_LEVEL, new_zero);
			cfg_write(CFG_SPARE_A, LEVEL_W'($urandom));
			cfg_write(CFG_SPARE_B, LEVEL_W'($urandom));
			cfg_done();
			if (ph == N_PHASES - 1) begin
				quiet = 1'b1;
			end
			repeat (PHASE_CHARS) send_char(random_char(), 1'b0, '0);
			in_valid <= 1'b0;
		end

		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("PASS rtty_char_serializer_crc16");
		end else begin
			$display("FAIL rtty_char_serializer_crc16");
		end
		$finish;
	end

endmodule
